/* hdl/day_bitmap_set_macros.svh */
// Assertion macros shared by the day bitmap set checker.
// No dependencies; included by files that assert.
`ifndef DAY_BITMAP_SET_MACROS_SVH
`define DAY_BITMAP_SET_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DBS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dbs_pkg.sv */
// Shared types, constants and codes of the day bitmap set.
// No dependencies; used by every other file of the block but the macros header.
`default_nettype none

package dbs_pkg;

  // Window size in days; a power of two from 8 to 65536.
  localparam int WINDOW_DAYS = 512;
  localparam int DAY_W       = 24;
  localparam int WORD_W      = (WINDOW_DAYS >= 64) ? 32 : WINDOW_DAYS / 2;
  localparam int IDX_W       = $clog2(WINDOW_DAYS);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int ROW_W       = IDX_W - BIT_W;
  localparam int NWORDS      = 1 << ROW_W;
  localparam int ADDR_W      = 3;

  localparam logic [2:0] ACT_SET  = 3'd0;
  localparam logic [2:0] ACT_CLR  = 3'd1;
  localparam logic [2:0] ACT_TDAY = 3'd2;
  localparam logic [2:0] ACT_TRNG = 3'd3;
  localparam logic [2:0] ACT_NEXT = 3'd4;
  localparam logic [2:0] ACT_PREV = 3'd5;

  localparam logic ADDR_WINDOW_START = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_CLR,
    OP_TEST,
    OP_NEXT,
    OP_PREV
  } dbs_op_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DECIDE,
    ST_RD,
    ST_EX,
    ST_FIN
  } dbs_state_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [DAY_W-1:0] first_day;
    logic [DAY_W-1:0] last_day;
  } dbs_req_t;

  typedef struct packed {
    logic             status;
    logic             answer;
    logic             found;
    logic [DAY_W-1:0] found_day;
    logic             set_empty;
    logic [DAY_W-1:0] bound_first;
    logic [DAY_W-1:0] bound_last;
  } dbs_rsp_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic rd;
    logic ex;
    logic fin;
  } dbs_cmd_t;

  typedef struct packed {
    logic walk;
    logic last;
    logic stop;
    logic sweep_last;
  } dbs_sts_t;

endpackage

`default_nettype wire

/* hdl/day_bitmap_set.sv */
// Top level of the day bitmap set: configuration port, controller, datapath.
// Depends on dbs_pkg, dbs_ctrl and dbs_dpath.
`default_nettype none

// The block keeps one membership bit per day over a window of WINDOW_DAYS
// days that starts at window_start, together with the first and last member
// day. A request is accepted when start is high, busy is low and no write of
// window_start comes in the same cycle. Each request produces exactly one
// result, shown on out_rsp for a single cycle while out_strobe is high; the
// receiver cannot stall, so it must take the result in that cycle. Range and
// search requests walk the bitmap memory one 32-bit word at a time, with a
// read state and a process state per word, over the 1 to 16 words that the
// range or search touches; requests that need no walk go from the decide
// state straight to the finish state. The strobe rises in the first cycle
// that busy is low, and a new transaction may be accepted in that same
// cycle. After reset, and after every write of window_start, the block
// clears the bitmap memory one word per cycle, with busy held high. Writes
// to window_start are only allowed while busy is low.
module day_bitmap_set (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Request channel.
  input  wire logic                         start,
  output logic                              busy,
  input  wire dbs_pkg::dbs_req_t            in_req,
  // Result channel.
  output logic                              out_strobe,
  output dbs_pkg::dbs_rsp_t                 out_rsp,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dbs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  dbs_pkg::dbs_cmd_t cmd;
  dbs_pkg::dbs_sts_t sts;
  logic                      cfg_we;
  logic [dbs_pkg::DAY_W-1:0] window_start;

  // Byte addresses 0 to 3 all select the one register; writes to 4 to 7 are dropped.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == dbs_pkg::ADDR_WINDOW_START);

  always_comb begin
    if (paddr[2] == dbs_pkg::ADDR_WINDOW_START) prdata = 32'(window_start);
    else prdata = '0;
  end

  dbs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_we (cfg_we),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  dbs_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[dbs_pkg::DAY_W-1:0]),
    .req          (in_req),
    .sts          (sts),
    .window_start (window_start),
    .out_strobe   (out_strobe),
    .out_rsp      (out_rsp)
  );

endmodule

`default_nettype wire

/* hdl/dbs_ctrl.sv */
// Controller state machine of the day bitmap set.
// Depends on dbs_pkg; drives the datapath through command signals.
`default_nettype none

module dbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              cfg_we,
  input  wire dbs_pkg::dbs_sts_t sts,
  output dbs_pkg::dbs_cmd_t      cmd,
  output logic                   busy
);

  dbs_pkg::dbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dbs_pkg::ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dbs_pkg::ST_SWEEP: begin
        if (sts.sweep_last) state_nxt = dbs_pkg::ST_IDLE;
      end
      dbs_pkg::ST_IDLE: begin
        if (cfg_we) state_nxt = dbs_pkg::ST_SWEEP;
        else if (start) state_nxt = dbs_pkg::ST_DECIDE;
      end
      dbs_pkg::ST_DECIDE: begin
        state_nxt = sts.walk ? dbs_pkg::ST_RD : dbs_pkg::ST_FIN;
      end
      dbs_pkg::ST_RD: begin
        state_nxt = dbs_pkg::ST_EX;
      end
      dbs_pkg::ST_EX: begin
        state_nxt = (sts.last || sts.stop) ? dbs_pkg::ST_FIN : dbs_pkg::ST_RD;
      end
      dbs_pkg::ST_FIN: begin
        state_nxt = dbs_pkg::ST_IDLE;
      end
      default: state_nxt = dbs_pkg::ST_SWEEP;
    endcase
  end

  always_comb begin
    busy      = (state_r != dbs_pkg::ST_IDLE);
    cmd.load  = (state_r == dbs_pkg::ST_IDLE) && start && !cfg_we;
    cmd.sweep = (state_r == dbs_pkg::ST_SWEEP);
    cmd.rd    = (state_r == dbs_pkg::ST_RD);
    cmd.ex    = (state_r == dbs_pkg::ST_EX);
    cmd.fin   = (state_r == dbs_pkg::ST_FIN);
  end

endmodule

`default_nettype wire

/* hdl/dbs_dpath.sv */
// Datapath of the day bitmap set: bitmap memory, bounds and word walker.
// Depends on dbs_pkg; sequenced by dbs_ctrl.
`default_nettype none

module dbs_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dbs_pkg::dbs_cmd_t         cmd,
  input  wire logic                      cfg_we,
  input  wire logic [dbs_pkg::DAY_W-1:0] cfg_wdata,
  input  wire dbs_pkg::dbs_req_t         req,
  output dbs_pkg::dbs_sts_t              sts,
  output logic [dbs_pkg::DAY_W-1:0]      window_start,
  output logic                           out_strobe,
  output dbs_pkg::dbs_rsp_t              out_rsp
);

  localparam int DW = dbs_pkg::DAY_W;
  localparam int IW = dbs_pkg::IDX_W;
  localparam int BW = dbs_pkg::BIT_W;
  localparam int RW = dbs_pkg::ROW_W;
  localparam int WW = dbs_pkg::WORD_W;

  function automatic logic [BW-1:0] oh2bin(input logic [WW-1:0] oh);
    logic [BW-1:0] b;
    b = '0;
    for (int i = 0; i < WW; i++) begin
      if (oh[i]) b = b | BW'(i);
    end
    return b;
  endfunction

  function automatic logic [BW-1:0] lsb_pos(input logic [WW-1:0] x);
    logic [WW-1:0] iso;
    iso = x & (~x + WW'(1));
    return oh2bin(iso);
  endfunction

  function automatic logic [BW-1:0] msb_pos(input logic [WW-1:0] x);
    logic [WW-1:0] r;
    for (int i = 0; i < WW; i++) r[i] = x[WW-1-i];
    return BW'(WW - 1) - lsb_pos(r);
  endfunction

  function automatic logic [IW-1:0] idx_of(input logic [DW-1:0] day,
                                           input logic [DW-1:0] base);
    logic [DW-1:0] d;
    d = day - base;
    return d[IW-1:0];
  endfunction

  function automatic logic in_win(input logic [DW-1:0] day,
                                  input logic [DW-1:0] base);
    logic [DW-1:0] d;
    d = day - base;
    return (day >= base) && (d < DW'(dbs_pkg::WINDOW_DAYS));
  endfunction

  // Architectural state.
  logic [DW-1:0] ws_r, low_r, high_r, low_nxt, high_nxt;
  logic          has_r, has_nxt;
  logic [RW-1:0] sweep_ptr_r;
  logic [WW-1:0] mem [dbs_pkg::NWORDS];
  logic [WW-1:0] rd_data_r;

  // Per-transaction working registers.
  dbs_pkg::dbs_op_t op_r, op_nxt;
  logic          walk_r, walk_nxt, down_r, down_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [RW-1:0] wptr_r, wbeg_nxt, wend_r, wend_nxt;
  logic          status_r, status_nxt, flag_r, flag_nxt, found_r, found_nxt;
  logic [DW-1:0] fday_r, fday_nxt, fd_r, ld_r;
  logic          any_r;
  logic [IW-1:0] nlo_r, nhi_r;
  logic          out_strobe_r;
  dbs_pkg::dbs_rsp_t out_rsp_r;

  // Decode of a newly accepted transaction.
  logic [DW-1:0] fd, ld, clo, chi;
  logic [IW-1:0] fdi, ldi, lidx, hidx;

  always_comb begin
    fd   = req.first_day;
    ld   = req.last_day;
    fdi  = idx_of(fd, ws_r);
    ldi  = idx_of(ld, ws_r);
    lidx = idx_of(low_r, ws_r);
    hidx = idx_of(high_r, ws_r);
    clo  = (fd > low_r) ? fd : low_r;
    chi  = (ld < high_r) ? ld : high_r;
    op_nxt = dbs_pkg::OP_NONE;
    walk_nxt = 1'b0;
    down_nxt = 1'b0;
    lo_nxt = '0;
    hi_nxt = '0;
    status_nxt = 1'b0;
    flag_nxt = 1'b0;
    found_nxt = 1'b0;
    fday_nxt = '0;
    case (req.action)
      dbs_pkg::ACT_SET: begin
        op_nxt = dbs_pkg::OP_SET;
        if (fd <= ld) begin
          if (!in_win(fd, ws_r) || !in_win(ld, ws_r)) begin
            status_nxt = 1'b1;
          end else begin
            walk_nxt = 1'b1;
            lo_nxt = fdi;
            hi_nxt = ldi;
          end
        end
      end
      dbs_pkg::ACT_CLR: begin
        op_nxt = dbs_pkg::OP_CLR;
        if (fd <= ld && has_r && clo <= chi) begin
          walk_nxt = 1'b1;
          lo_nxt = idx_of(clo, ws_r);
          hi_nxt = idx_of(chi, ws_r);
        end
      end
      dbs_pkg::ACT_TDAY: begin
        op_nxt = dbs_pkg::OP_TEST;
        if (has_r && fd >= low_r && fd <= high_r) begin
          walk_nxt = 1'b1;
          flag_nxt = 1'b1;
          lo_nxt = fdi;
          hi_nxt = fdi;
        end
      end
      dbs_pkg::ACT_TRNG: begin
        op_nxt = dbs_pkg::OP_TEST;
        if (fd <= ld && has_r && fd >= low_r && ld <= high_r) begin
          walk_nxt = 1'b1;
          flag_nxt = 1'b1;
          lo_nxt = fdi;
          hi_nxt = ldi;
        end
      end
      dbs_pkg::ACT_NEXT: begin
        op_nxt = dbs_pkg::OP_NEXT;
        if (has_r && fd < high_r) begin
          if (fd < low_r) begin
            found_nxt = 1'b1;
            fday_nxt = low_r;
          end else begin
            walk_nxt = 1'b1;
            lo_nxt = fdi + IW'(1);
            hi_nxt = hidx;
          end
        end
      end
      dbs_pkg::ACT_PREV: begin
        op_nxt = dbs_pkg::OP_PREV;
        if (has_r && fd > low_r) begin
          if (fd > high_r) begin
            found_nxt = 1'b1;
            fday_nxt = high_r;
          end else begin
            walk_nxt = 1'b1;
            down_nxt = 1'b1;
            lo_nxt = lidx;
            hi_nxt = fdi - IW'(1);
          end
        end
      end
      default: ;
    endcase
    // A clear rescans the whole member span to rebuild the bounds.
    if (op_nxt == dbs_pkg::OP_CLR) begin
      wbeg_nxt = lidx[IW-1:BW];
      wend_nxt = hidx[IW-1:BW];
    end else if (down_nxt) begin
      wbeg_nxt = hi_nxt[IW-1:BW];
      wend_nxt = lo_nxt[IW-1:BW];
    end else begin
      wbeg_nxt = lo_nxt[IW-1:BW];
      wend_nxt = hi_nxt[IW-1:BW];
    end
  end

  // Per-word processing.
  logic [RW-1:0] lo_w, hi_w;
  logic [BW-1:0] lo_b, hi_b, hit_lsb, hit_msb, clr_lsb, clr_msb;
  logic [WW-1:0] lowm, highm, mask, hits, cleared;
  logic          hit_any, mem_we;
  logic [RW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;

  always_comb begin
    lo_w  = lo_r[IW-1:BW];
    hi_w  = hi_r[IW-1:BW];
    lo_b  = lo_r[BW-1:0];
    hi_b  = hi_r[BW-1:0];
    if (wptr_r == lo_w) lowm = {WW{1'b1}} << lo_b;
    else lowm = (wptr_r > lo_w) ? {WW{1'b1}} : '0;
    if (wptr_r == hi_w) highm = {WW{1'b1}} >> (BW'(WW - 1) - hi_b);
    else highm = (wptr_r < hi_w) ? {WW{1'b1}} : '0;
    mask    = lowm & highm;
    hits    = rd_data_r & mask;
    cleared = rd_data_r & ~mask;
    hit_any = (hits != '0);
    hit_lsb = lsb_pos(hits);
    hit_msb = msb_pos(hits);
    clr_lsb = lsb_pos(cleared);
    clr_msb = msb_pos(cleared);

    mem_we    = cmd.sweep ||
                (cmd.ex && (op_r == dbs_pkg::OP_SET || op_r == dbs_pkg::OP_CLR));
    mem_waddr = cmd.sweep ? sweep_ptr_r : wptr_r;
    if (cmd.sweep) mem_wdata = '0;
    else if (op_r == dbs_pkg::OP_SET) mem_wdata = rd_data_r | mask;
    else mem_wdata = cleared;

    sts.walk       = walk_r;
    sts.last       = (wptr_r == wend_r);
    sts.stop       = hit_any && (op_r == dbs_pkg::OP_NEXT || op_r == dbs_pkg::OP_PREV);
    sts.sweep_last = (sweep_ptr_r == RW'(dbs_pkg::NWORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd) rd_data_r <= mem[wptr_r];
  end

  // Bound update at the end of a set or clear walk, or on a window change.
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    has_nxt  = has_r;
    if (cfg_we) begin
      low_nxt  = '0;
      high_nxt = '0;
      has_nxt  = 1'b0;
    end else if (cmd.fin && walk_r && op_r == dbs_pkg::OP_SET) begin
      has_nxt = 1'b1;
      if (!has_r) begin
        low_nxt  = fd_r;
        high_nxt = ld_r;
      end else begin
        if (fd_r < low_r) low_nxt = fd_r;
        if (ld_r > high_r) high_nxt = ld_r;
      end
    end else if (cmd.fin && walk_r && op_r == dbs_pkg::OP_CLR) begin
      has_nxt = any_r;
      low_nxt  = any_r ? ws_r + DW'(nlo_r) : '0;
      high_nxt = any_r ? ws_r + DW'(nhi_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r         <= '0;
      low_r        <= '0;
      high_r       <= '0;
      has_r        <= 1'b0;
      sweep_ptr_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) ws_r <= cfg_wdata;
      low_r  <= low_nxt;
      high_r <= high_nxt;
      has_r  <= has_nxt;
      if (cfg_we) sweep_ptr_r <= '0;
      else if (cmd.sweep) sweep_ptr_r <= sweep_ptr_r + RW'(1);
      out_strobe_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_nxt;
      walk_r   <= walk_nxt;
      down_r   <= down_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      wptr_r   <= wbeg_nxt;
      wend_r   <= wend_nxt;
      status_r <= status_nxt;
      flag_r   <= flag_nxt;
      found_r  <= found_nxt;
      fday_r   <= fday_nxt;
      fd_r     <= fd;
      ld_r     <= ld;
      any_r    <= 1'b0;
      nlo_r    <= '0;
      nhi_r    <= '0;
    end else if (cmd.ex) begin
      wptr_r <= down_r ? wptr_r - RW'(1) : wptr_r + RW'(1);
      case (op_r)
        dbs_pkg::OP_TEST: begin
          if (hits != mask) flag_r <= 1'b0;
        end
        dbs_pkg::OP_NEXT: begin
          if (hit_any) begin
            found_r <= 1'b1;
            fday_r  <= ws_r + DW'({wptr_r, hit_lsb});
          end
        end
        dbs_pkg::OP_PREV: begin
          if (hit_any) begin
            found_r <= 1'b1;
            fday_r  <= ws_r + DW'({wptr_r, hit_msb});
          end
        end
        dbs_pkg::OP_CLR: begin
          if (cleared != '0) begin
            if (!any_r) nlo_r <= {wptr_r, clr_lsb};
            nhi_r <= {wptr_r, clr_msb};
            any_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.fin) begin
      out_rsp_r.status      <= status_r;
      out_rsp_r.answer      <= flag_r;
      out_rsp_r.found       <= found_r;
      out_rsp_r.found_day   <= fday_r;
      out_rsp_r.set_empty   <= !has_nxt;
      out_rsp_r.bound_first <= low_nxt;
      out_rsp_r.bound_last  <= high_nxt;
    end
  end

  assign window_start = ws_r;
  assign out_strobe   = out_strobe_r;
  assign out_rsp      = out_rsp_r;

endmodule

`default_nettype wire

/* hdl/dbs_checker.sv */
// Port-level checker of the day bitmap set, bound to the top level.
// Depends on dbs_pkg and day_bitmap_set_macros.svh.
`default_nettype none

`include "day_bitmap_set_macros.svh"

module dbs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_strobe,
  input wire dbs_pkg::dbs_rsp_t out_rsp
);

  // A result only follows a transaction in progress.
  `DBS_ASSERT_SAME(a_strobe_after_busy, out_strobe, $past(busy), "result without a transaction")
  // An accepted transaction makes the block busy.
  `DBS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "accept did not raise busy")
  // Two results are never back to back.
  `DBS_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "strobe lasted two cycles")
  // An empty set reports zero bounds.
  `DBS_ASSERT_SAME(a_empty_bounds, out_strobe && out_rsp.set_empty,
                   out_rsp.bound_first == '0 && out_rsp.bound_last == '0,
                   "empty set with nonzero bounds")
  // A missed search reports day zero.
  `DBS_ASSERT_SAME(a_notfound_zero, out_strobe && !out_rsp.found,
                   out_rsp.found_day == '0, "found_day set without a find")

endmodule

bind day_bitmap_set dbs_checker u_dbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);

`default_nettype wire

/* verif/day_bitmap_set_test.sv */
// Self-checking testbench for the day bitmap set top level.
// Depends on dbs_pkg and the day_bitmap_set RTL; predicts every result itself.
`timescale 1ns / 100ps
`default_nettype none

module day_bitmap_set_test;
  import dbs_pkg::*;

  // Action codes the block must treat as no-ops.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam logic [23:0] DAY_MAX = 24'hFFFFFF;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dbs_req_t in_req = '0;
  logic out_strobe;
  dbs_rsp_t out_rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  day_bitmap_set uut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_rsp(out_rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // A 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the membership store, its bounds and the window register.
  bit          member_bits[WINDOW_DAYS];
  logic [23:0] shadow_low;
  logic [23:0] shadow_high;
  bit          shadow_any;
  logic [23:0] shadow_window;

  dbs_rsp_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_enabled = 1'b1;

  // The whole run is bounded by a cycle counter; a hung block fails here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Clearing the shadow state mirrors what reset and a window write do.
  function automatic void clear_shadow();
    foreach (member_bits[i]) member_bits[i] = 1'b0;
    shadow_low = '0;
    shadow_high = '0;
    shadow_any = 1'b0;
  endfunction

  function automatic bit day_in_window(input logic [23:0] day);
    return (day >= shadow_window) && ((32'(day) - 32'(shadow_window)) < WINDOW_DAYS);
  endfunction

  function automatic int unsigned slot_of(input logic [23:0] day);
    return (32'(day) - 32'(shadow_window)) % WINDOW_DAYS;
  endfunction

  // Works out the result of one request and applies its effect on the store.
  function automatic dbs_rsp_t apply_request(input dbs_req_t req);
    dbs_rsp_t r;
    logic [23:0] fd, ld, lo, hi;
    int unsigned nlo, nhi;
    bit any;
    r = '0;
    fd = req.first_day;
    ld = req.last_day;
    case (req.action)
      ACT_SET: begin
        if (fd <= ld) begin
          if (!day_in_window(fd) || !day_in_window(ld)) begin
            r.status = 1'b1;
          end else begin
            for (int unsigned i = slot_of(fd); i <= slot_of(ld); i++) member_bits[i] = 1'b1;
            if (!shadow_any) begin
              shadow_low = fd;
              shadow_high = ld;
              shadow_any = 1'b1;
            end else begin
              if (fd < shadow_low) shadow_low = fd;
              if (ld > shadow_high) shadow_high = ld;
            end
          end
        end
      end
      ACT_CLR: begin
        lo = (fd > shadow_low) ? fd : shadow_low;
        hi = (ld < shadow_high) ? ld : shadow_high;
        if (fd <= ld && shadow_any && lo <= hi) begin
          for (int unsigned i = slot_of(lo); i <= slot_of(hi); i++) member_bits[i] = 1'b0;
          any = 1'b0;
          nlo = 0;
          nhi = 0;
          for (int unsigned i = slot_of(shadow_low); i <= slot_of(shadow_high); i++) begin
            if (member_bits[i]) begin
              if (!any) nlo = i;
              nhi = i;
              any = 1'b1;
            end
          end
          if (any) begin
            shadow_low = shadow_window + 24'(nlo);
            shadow_high = shadow_window + 24'(nhi);
          end else begin
            clear_shadow();
          end
        end
      end
      ACT_TDAY: begin
        if (shadow_any && fd >= shadow_low && fd <= shadow_high)
          r.answer = member_bits[slot_of(fd)];
      end
      ACT_TRNG: begin
        if (fd <= ld && shadow_any && fd >= shadow_low && ld <= shadow_high) begin
          r.answer = 1'b1;
          for (int unsigned i = slot_of(fd); i <= slot_of(ld); i++)
            if (!member_bits[i]) r.answer = 1'b0;
        end
      end
      ACT_NEXT: begin
        if (shadow_any && fd < shadow_high) begin
          if (fd < shadow_low) begin
            r.found = 1'b1;
            r.found_day = shadow_low;
          end else begin
            for (int unsigned i = slot_of(fd) + 1; i <= slot_of(shadow_high); i++) begin
              if (member_bits[i] && !r.found) begin
                r.found = 1'b1;
                r.found_day = shadow_window + 24'(i);
              end
            end
          end
        end
      end
      ACT_PREV: begin
        if (shadow_any && fd > shadow_low) begin
          if (fd > shadow_high) begin
            r.found = 1'b1;
            r.found_day = shadow_high;
          end else begin
            for (int unsigned i = slot_of(fd); i > slot_of(shadow_low); i--) begin
              if (member_bits[i-1] && !r.found) begin
                r.found = 1'b1;
                r.found_day = shadow_window + 24'(i - 1);
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.set_empty = !shadow_any;
    r.bound_first = shadow_low;
    r.bound_last = shadow_high;
    return r;
  endfunction

  // Each strobed result is matched with the oldest prediction, field by field.
  always @(posedge clk) begin
    dbs_rsp_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with none outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch($sformatf("status %0b, want %0b", out_rsp.status, want.status));
        if (out_rsp.answer !== want.answer)
          report_mismatch($sformatf("answer %0b, want %0b", out_rsp.answer, want.answer));
        if (out_rsp.found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", out_rsp.found, want.found));
        if (out_rsp.found_day !== want.found_day)
          report_mismatch($sformatf("found_day %0d, want %0d",
                                    out_rsp.found_day, want.found_day));
        if (out_rsp.set_empty !== want.set_empty)
          report_mismatch($sformatf("set_empty %0b, want %0b",
                                    out_rsp.set_empty, want.set_empty));
        if (out_rsp.bound_first !== want.bound_first)
          report_mismatch($sformatf("bound_first %0d, want %0d",
                                    out_rsp.bound_first, want.bound_first));
        if (out_rsp.bound_last !== want.bound_last)
          report_mismatch($sformatf("bound_last %0d, want %0d",
                                    out_rsp.bound_last, want.bound_last));
      end
    end
  end

  // Sends one request, optionally after a random idle burst. The prediction
  // is queued at the edge that accepts the transaction, so order is kept.
  task automatic send_request(input logic [2:0] act, input logic [23:0] fd,
                              input logic [23:0] ld);
    dbs_req_t req;
    req.action = act;
    req.first_day = fd;
    req.last_day = ld;
    if (idle_enabled && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    in_req <= req;
    // Busy is looked at mid-cycle, away from the edge where it changes.
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_results.push_back(apply_request(req));
    start <= 1'b0;
  endtask

  // Waits until every predicted result has been checked and the block is idle.
  task automatic drain_results();
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  // Writes window_start through the configuration port once the block is idle.
  task automatic write_window(input logic [23:0] value);
    drain_results();
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(ADDR_WINDOW_START) << 2;
    pwdata <= {8'h00, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_window = value;
    clear_shadow();
  endtask

  // A day chosen mostly inside the window, sometimes just outside it, and
  // sometimes anywhere in the 24-bit range so every bit gets exercised.
  function automatic logic [23:0] pick_day();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) return shadow_window + 24'($urandom_range(0, WINDOW_DAYS - 1));
    if (sel < 17) return shadow_window + 24'(WINDOW_DAYS + $urandom_range(0, 3));
    if (sel < 18) return shadow_window - 24'($urandom_range(1, 4));
    return 24'($urandom);
  endfunction

  // One random request: mostly well-formed short ranges inside the window,
  // with reversed ranges, spare codes and wild days mixed in.
  task automatic send_random_request();
    logic [2:0] act;
    logic [23:0] fd, ld;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) act = ACT_SET;
    else if (roll < 37) act = ACT_CLR;
    else if (roll < 50) act = ACT_TDAY;
    else if (roll < 63) act = ACT_TRNG;
    else if (roll < 79) act = ACT_NEXT;
    else if (roll < 95) act = ACT_PREV;
    else act = 3'($urandom_range(6, 7));
    fd = pick_day();
    if ($urandom_range(0, 9) == 0) ld = pick_day();
    else ld = fd + 24'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 200 : 12));
    send_request(act, fd, ld);
  endtask

  // Directed pass over every action and the corner cases, in window zero.
  task automatic test_directed_actions();
    write_window(24'd0);
    send_request(ACT_TDAY, 24'd5, 24'd5);             // test on an empty store
    send_request(ACT_NEXT, 24'd0, 24'd0);             // search on an empty store
    send_request(ACT_SET, 24'd0, 24'd0);              // lowest day of the window
    send_request(ACT_SET, 24'd511, 24'd511);          // highest day of the window
    send_request(ACT_SET, 24'd510, 24'd512);          // set running past the window
    send_request(ACT_SET, 24'd9, 24'd3);              // reversed range is a no-op
    send_request(ACT_SET, 24'd100, 24'd140);
    send_request(ACT_TRNG, 24'd100, 24'd140);
    send_request(ACT_TRNG, 24'd99, 24'd140);
    send_request(ACT_TRNG, 24'd140, 24'd100);         // reversed test range
    send_request(ACT_TDAY, 24'd511, 24'd0);
    send_request(ACT_NEXT, 24'd0, 24'd0);
    send_request(ACT_NEXT, 24'd140, 24'd0);
    send_request(ACT_PREV, 24'd511, 24'd0);
    send_request(ACT_PREV, DAY_MAX, 24'd0);           // past the highest member
    send_request(ACT_PREV, 24'd100, 24'd0);
    send_request(ACT_SPARE_A, DAY_MAX, DAY_MAX);      // spare codes change nothing
    send_request(ACT_SPARE_B, 24'd1, 24'd2);
    send_request(ACT_CLR, 24'd0, 24'd120);            // clear moves the low bound
    send_request(ACT_CLR, 24'd500, DAY_MAX);          // clear moves the high bound
    send_request(ACT_CLR, 24'd9, 24'd3);
    send_request(ACT_CLR, 24'd0, DAY_MAX);            // clear empties the store
    send_request(ACT_CLR, 24'd0, DAY_MAX);            // clear on an empty store
  endtask

  // Windows at the top end of the day range, where days past the top
  // cannot be named.
  task automatic test_window_extremes();
    write_window(DAY_MAX);
    send_request(ACT_SET, DAY_MAX, DAY_MAX);
    send_request(ACT_NEXT, 24'd0, 24'd0);
    send_request(ACT_PREV, DAY_MAX, 24'd0);
    send_request(ACT_SET, DAY_MAX - 24'd1, DAY_MAX);
    repeat (40) send_random_request();
    write_window(DAY_MAX - 24'(WINDOW_DAYS - 1));
    send_request(ACT_SET, DAY_MAX - 24'(WINDOW_DAYS - 1), DAY_MAX);
    send_request(ACT_TRNG, DAY_MAX - 24'(WINDOW_DAYS - 1), DAY_MAX);
    repeat (100) send_random_request();
  endtask

  // Long random phases across several window positions.
  task automatic test_random_windows();
    logic [23:0] windows[4];
    windows[0] = 24'd0;
    windows[1] = 24'($urandom);
    windows[2] = 24'h800000;
    windows[3] = 24'($urandom);
    foreach (windows[w]) begin
      write_window(windows[w]);
      repeat (350) send_random_request();
    end
  endtask

  // The sender holds off until the block has returned everything, then
  // finishes with back-to-back traffic and no idle cycles.
  task automatic test_drain_and_burst();
    drain_results();
    idle_enabled = 1'b0;
    repeat (250) send_random_request();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    shadow_window = '0;
    clear_shadow();
    test_directed_actions();
    test_window_extremes();
    test_random_windows();
    test_drain_and_burst();
    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
